@@ src/thst_pkg.sv @@
package thst_pkg;

  localparam int unsigned ZonesDef = 16;

  localparam int unsigned TempW = 12;
  localparam int unsigned ZoneW = 4;
  localparam int unsigned HystW = 8;
  localparam int unsigned EvW   = 2;

  localparam logic signed [TempW-1:0] SetpointReset = 12'sd320;
  localparam logic [HystW-1:0]        HystReset     = 8'd8;

  localparam logic CmdRead = 1'b0;
  localparam logic CmdSet  = 1'b1;

  typedef enum logic [EvW-1:0] {
    EV_START = 2'd0,
    EV_STOP  = 2'd1,
    EV_ACK   = 2'd2
  } event_e;

  typedef struct packed {
    logic                    relay;
    logic signed [TempW-1:0] sp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

@@ src/thst_ram.sv @@
module thst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/multi_zone_hysteresis_thermostat.sv @@
// Stages: RAM read into the compare stage, then compare and write-back into the result beat.
// Throughput: one item per cycle while results drain; a stalled result holds the compare stage.
// Back-to-back items on one zone use a forwarded copy of the entry just written.
// Reset: async, active low. Per-zone valid flops make every zone read as 20 C, relay off;
// no clearing pass. Hysteresis resets to 8 (0.5 C).
module multi_zone_hysteresis_thermostat #(
  parameter int unsigned ZONES = thst_pkg::ZonesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [thst_pkg::HystW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // zone[3:0], value[15:4]
  input  logic                       s_axis_tuser,   // command
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // zone_res[3:0], level[15:4]
  output logic [thst_pkg::EvW-1:0]   m_axis_tuser    // event_res
);

  import thst_pkg::*;

  localparam int unsigned AW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int unsigned CmpW = TempW + 2;

  logic [HystW-1:0] hyst_q;

  logic [ZoneW-1:0]        in_zone;
  logic signed [TempW-1:0] in_val;
  logic [AW-1:0]           in_idx;
  logic                    acc;

  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_cmd_q;
  logic [ZoneW-1:0]        s1_zone_q;
  logic signed [TempW-1:0] s1_val_q;
  logic                    s1_inr_q;
  logic [AW-1:0]           s1_idx;
  logic                    s1_go;

  logic                    fwd_q, fwd_d;
  entry_t                  fwd_data_q;
  logic [ZONES-1:0]        valid_q;

  logic [EntryW-1:0] rdata;
  entry_t            cur, nxt;
  logic              wr;
  logic              hit;
  event_e            ev;

  logic signed [CmpW-1:0] val_x, sp_x, lim_x;

  logic                    out_valid_q, out_valid_d;
  logic [ZoneW-1:0]        out_zone_q;
  event_e                  out_ev_q;
  logic signed [TempW-1:0] out_level_q;

  assign in_zone = s_axis_tdata[ZoneW-1:0];
  assign in_val  = s_axis_tdata[ZoneW +: TempW];
  assign in_idx  = AW'(in_zone);
  assign acc     = s_axis_tvalid && s_axis_tready;

  assign s1_idx        = AW'(s1_zone_q);
  assign s1_go         = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_go;

  thst_ram #(
    .WIDTH (EntryW),
    .DEPTH (ZONES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (s1_idx),
    .wdata_i (nxt),
    .re_i    (acc),
    .raddr_i (in_idx),
    .rdata_o (rdata)
  );

  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (valid_q[s1_idx]) begin
      cur = entry_t'(rdata);
    end else begin
      cur = '{relay: 1'b0, sp: SetpointReset};
    end
  end

  assign val_x = {{2{s1_val_q[TempW-1]}}, s1_val_q};
  assign sp_x  = {{2{cur.sp[TempW-1]}}, cur.sp};
  assign lim_x = sp_x + $signed({{(CmpW-HystW){1'b0}}, hyst_q});

  always_comb begin
    nxt = cur;
    hit = 1'b0;
    ev  = EV_ACK;
    if (s1_cmd_q == CmdSet) begin
      nxt.sp = s1_val_q;
      hit    = 1'b1;
      ev     = EV_ACK;
    end else if (!cur.relay) begin
      if (val_x <= sp_x) begin
        nxt.relay = 1'b1;
        hit       = 1'b1;
        ev        = EV_START;
      end
    end else if (val_x > lim_x) begin
      nxt.relay = 1'b0;
      hit       = 1'b1;
      ev        = EV_STOP;
    end
  end

  assign wr    = s1_go && s1_inr_q;
  assign fwd_d = acc && wr && (in_idx == s1_idx);

  always_comb begin
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    if (s1_go) begin
      out_valid_d = s1_inr_q && hit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q      <= HystReset;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hyst_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      // forward select stays with the entry while it waits in the compare stage
      if (acc) begin
        fwd_q <= fwd_d;
      end
      out_valid_q <= out_valid_d;
      if (wr) begin
        valid_q[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_cmd_q  <= s_axis_tuser;
      s1_zone_q <= in_zone;
      s1_val_q  <= in_val;
      s1_inr_q  <= 32'(in_zone) < ZONES;
    end
    if (fwd_d) begin
      fwd_data_q <= nxt;
    end
    if (s1_go && hit) begin
      out_zone_q  <= s1_zone_q;
      out_ev_q    <= ev;
      out_level_q <= s1_val_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_level_q, out_zone_q};
  assign m_axis_tuser  = out_ev_q;

endmodule

@@ src/thst_chk.sv @@
module thst_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [15:0]                s_axis_tdata,
  input logic                       s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [15:0]                m_axis_tdata,
  input logic [thst_pkg::EvW-1:0]   m_axis_tuser
);

  import thst_pkg::*;

  // a held result beat stays up until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // every fresh result comes from an accepted input beat, via the compare stage and output register
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without a causing input beat");

  // a setpoint write to zone 0 into an empty pipe yields an ack carrying the same zone and value
  a_ack_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CmdSet) && !m_axis_tvalid
      && !$past(s_axis_tvalid && s_axis_tready) && (s_axis_tdata[3:0] == 4'd0)
    |=> ##1 m_axis_tvalid && (m_axis_tuser == EV_ACK)
      && (m_axis_tdata == $past(s_axis_tdata, 2)))
    else $error("setpoint ack mismatch");

  a_ev_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == EV_START) || (m_axis_tuser == EV_STOP)
      || (m_axis_tuser == EV_ACK))
    else $error("illegal event code");

endmodule

bind multi_zone_hysteresis_thermostat thst_chk u_thst_chk (.*);

@@ test/tb_multi_zone_hysteresis_thermostat.sv @@
module tb_multi_zone_hysteresis_thermostat;
  timeunit 1ns;
  timeprecision 1ps;

  import thst_pkg::*;

  localparam int unsigned NumZones         = ZonesDef;
  localparam int unsigned DrainCycles      = 6;
  localparam int unsigned SinkHoldCycles   = 160;
  localparam int unsigned CycleLimit       = 300000;
  localparam int unsigned MaxPrintedErrors = 40;

  typedef struct packed {
    logic [ZoneW-1:0]        zone;
    event_e                  ev;
    logic signed [TempW-1:0] level;
  } zone_event_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [HystW-1:0] cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;  // zone[3:0], value[15:4]
  logic             s_axis_tuser  = 1'b0; // command
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;         // zone_res[3:0], level[15:4]
  logic [EvW-1:0]   m_axis_tuser;         // event_res

  // thermostat state mirror
  logic signed [TempW-1:0] setpoint_mirror [NumZones];
  logic                    heater_mirror   [NumZones];
  logic [HystW-1:0]        hyst_mirror;

  zone_event_t pending_events [$];
  zone_event_t arrived_exp;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req     = 1'b0;
  bit          sink_hold    = 1'b0;
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned events_seen  = 0;
  int unsigned cycles       = 0;
  int unsigned input_stalls = 0;

  multi_zone_hysteresis_thermostat uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && s_axis_tvalid && !s_axis_tready) input_stalls++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d events outstanding", cycles,
               pending_events.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MaxPrintedErrors)
      $display("%0t MISMATCH %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // thermostat decision for one accepted beat
  task automatic update_zone_model(input logic cmd, input logic [ZoneW-1:0] zone,
                                   input logic signed [TempW-1:0] temp);
    zone_event_t ev_item;
    int          off_limit;
    ev_item.zone  = zone;
    ev_item.level = temp;
    off_limit = int'(setpoint_mirror[zone]) + int'(hyst_mirror);
    if (int'(zone) >= NumZones) return;
    if (cmd == CmdSet) begin
      setpoint_mirror[zone] = temp;
      ev_item.ev = EV_ACK;
      pending_events.push_back(ev_item);
    end else if (!heater_mirror[zone]) begin
      if (int'(temp) <= int'(setpoint_mirror[zone])) begin
        heater_mirror[zone] = 1'b1;
        ev_item.ev = EV_START;
        pending_events.push_back(ev_item);
      end
    end else if (int'(temp) > off_limit) begin
      heater_mirror[zone] = 1'b0;
      ev_item.ev = EV_STOP;
      pending_events.push_back(ev_item);
    end
  endtask

  // called at a rising edge; returns at the edge that accepts the beat
  task automatic send_item(input logic cmd, input logic [ZoneW-1:0] zone,
                           input logic signed [TempW-1:0] temp);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {temp, zone};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    update_zone_model(cmd, zone, temp);
  endtask

  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_hysteresis(input logic [HystW-1:0] margin);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= margin;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hyst_mirror = margin;
  endtask

  function automatic logic signed [TempW-1:0] clamp_temp(input int v);
    if (v > 2047) return 12'sd2047;
    if (v < -2048) return -12'sd2048;
    return v[TempW-1:0];
  endfunction

  // result checker and sink ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected beat, zone", int'(m_axis_tdata[3:0]), -1);
      end else begin
        arrived_exp = pending_events.pop_front();
        events_seen++;
        if (m_axis_tdata[3:0] !== arrived_exp.zone)
          report_mismatch("zone_res", int'(m_axis_tdata[3:0]), int'(arrived_exp.zone));
        if (m_axis_tuser !== arrived_exp.ev)
          report_mismatch("event_res", int'(m_axis_tuser), int'(arrived_exp.ev));
        if (m_axis_tdata[15:4] !== arrived_exp.level)
          report_mismatch("level", int'($signed(m_axis_tdata[15:4])),
                          int'(arrived_exp.level));
      end
    end
    if (!rst_ni || sink_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    forever begin
      wait (hold_req);
      sink_hold = 1'b1;
      repeat (SinkHoldCycles) @(posedge clk_i);
      sink_hold = 1'b0;
      hold_req  = 1'b0;
    end
  end

  task automatic test_reset_defaults();
    send_item(CmdRead, 4'd0, 12'sd320);  // equal to setpoint -> start
    send_item(CmdRead, 4'd0, 12'sd328);  // at setpoint + margin -> hold
    send_item(CmdRead, 4'd0, 12'sd329);  // above -> stop
    send_item(CmdRead, 4'd1, 12'sd321);  // above setpoint, relay off -> nothing
    send_item(CmdRead, 4'd1, 12'sd320);
    drain_block();
  endtask

  task automatic test_setpoint_extremes();
    send_item(CmdSet,  4'd15, 12'sd2047);
    send_item(CmdRead, 4'd15, 12'sd2047);
    send_item(CmdRead, 4'd15, 12'sd2047);  // no wrap of setpoint + margin
    send_item(CmdSet,  4'd2, -12'sd2048);
    send_item(CmdRead, 4'd2, -12'sd2047);
    send_item(CmdRead, 4'd2, -12'sd2048);
    send_item(CmdSet,  4'd2, -12'sd2048);  // unchanged value still acked
    send_item(CmdSet,  4'd2, 12'sd2047);   // relay not re-evaluated
    send_item(CmdRead, 4'd2, 12'sd2047);
    send_item(CmdRead, 4'd2, -12'sd2048);
    drain_block();
  endtask

  task automatic test_hysteresis_limits();
    set_hysteresis(8'd0);
    send_item(CmdRead, 4'd0, 12'sd320);
    send_item(CmdRead, 4'd0, 12'sd321);    // zero margin -> stop right above
    drain_block();
    set_hysteresis(8'd255);
    send_item(CmdSet,  4'd3, 12'sd2047);
    send_item(CmdRead, 4'd3, -12'sd2048);
    send_item(CmdRead, 4'd3, 12'sd2047);
    send_item(CmdSet,  4'd4, 12'sd0);
    send_item(CmdRead, 4'd4, 12'sd0);
    send_item(CmdRead, 4'd4, 12'sd255);
    send_item(CmdRead, 4'd4, 12'sd256);
    drain_block();
  endtask

  task automatic test_sink_holdoff();
    int unsigned k;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req = 1'b1;
    wait (sink_hold);
    for (k = 0; k < 40; k++)
      send_item(CmdSet, k[ZoneW-1:0], clamp_temp(int'($urandom_range(0, 800)) - 200));
    drain_block();
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned src_pct,
                                     input int unsigned snk_pct,
                                     input logic [HystW-1:0] margin);
    int unsigned       k;
    logic              cmd;
    logic [ZoneW-1:0]  zone;
    int                span;
    logic signed [TempW-1:0] temp;
    set_hysteresis(margin);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (k = 0; k < n; k++) begin
      cmd  = ($urandom_range(99) < 20) ? CmdSet : CmdRead;
      zone = ($urandom_range(99) < 50) ? ZoneW'($urandom_range(0, 3))
                                       : ZoneW'($urandom_range(0, 15));
      span = int'(hyst_mirror) + 16;
      if ($urandom_range(99) < 25)
        temp = TempW'($urandom);
      else if (cmd == CmdSet)
        temp = clamp_temp(int'($urandom_range(0, 400)) + 120);
      else
        temp = clamp_temp(int'(setpoint_mirror[zone]) +
                          int'($urandom_range(0, 2 * span)) - span);
      send_item(cmd, zone, temp);
    end
    drain_block();
  endtask

  initial begin
    int unsigned z;
    for (z = 0; z < NumZones; z++) begin
      setpoint_mirror[z] = SetpointReset;
      heater_mirror[z]   = 1'b0;
    end
    hyst_mirror = HystReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_setpoint_extremes();
    test_hysteresis_limits();
    test_sink_holdoff();
    test_random_traffic(225, 33, 65, 8'd0);
    test_random_traffic(225, 65, 33, 8'd255);
    test_random_traffic(225, 0, 0, HystW'($urandom_range(1, 254)));

    $display("Sent %0d beats, checked %0d events, input stalled %0d cycles",
             items_sent, events_seen, input_stalls);
    $display("Margins 0, 8, 255 and random; source/sink gaps, long sink hold-off");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
